@@ rtl/core/rotation_matrix_to_quaternion_defines.svh @@
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: assertion macros
// Shared concurrent assertion helpers; they compile to nothing under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`ifndef SYNTH
`define RMQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rmq: assertion failed");
`define RMQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rmq: assertion failed");
`else
`define RMQ_ASSERT(lbl, clk, rstn, prop)
`define RMQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/core/rmq_pkg.sv @@
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: package
// Widths, fixed-point constants and the types passed between the stages.
// ----------------------------------------------------------------------------
package rmq_pkg;
  localparam int FRAC_BITS = 14;
  localparam int DATA_W    = 16;
  localparam int VEC_W     = DATA_W + 2;
  localparam int NORM_W    = 30;
  localparam int SQ_W      = 2 * NORM_W + 2;
  localparam int ACC_W     = SQ_W + 1;
  localparam int ROOT_W    = SQ_W / 2;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int NUM_W     = NORM_W + QUO_W + 1;
  localparam int DEN_W     = ROOT_W + 1;
  localparam int SH_W      = 5;

  localparam logic signed [VEC_W-1:0] ONE_V = VEC_W'(1) <<< FRAC_BITS;
  localparam logic [QUO_W-1:0]        ONE_Q = QUO_W'(1) << FRAC_BITS;

  typedef logic [3:0][VEC_W-1:0]  vec4_t;
  typedef logic [3:0][NORM_W-1:0] mag4_t;

  // Unnormalized quaternion (x, y, z, w) and the small-root flag.
  typedef struct packed {
    vec4_t v;
    logic  degen;
  } vec_t;
endpackage

@@ rtl/core/rmq_mat_if.sv @@
// ----------------------------------------------------------------------------
// Matrix channel
// Valid/ready channel carrying the nine Q1.14 matrix elements.
// ----------------------------------------------------------------------------
interface rmq_mat_if;
  logic                               valid;
  logic                               ready;
  logic signed [rmq_pkg::DATA_W-1:0]  e00, e01, e02, e10, e11, e12, e20, e21, e22;

  modport source (output valid, e00, e01, e02, e10, e11, e12, e20, e21, e22,
                  input ready);
  modport sink (input valid, e00, e01, e02, e10, e11, e12, e20, e21, e22,
                output ready);
endinterface

@@ rtl/core/rmq_quat_if.sv @@
// ----------------------------------------------------------------------------
// Quaternion channel
// Valid/ready channel carrying the normalized quaternion and the flag.
// ----------------------------------------------------------------------------
interface rmq_quat_if;
  logic                               valid;
  logic                               ready;
  logic signed [rmq_pkg::DATA_W-1:0]  quat_x, quat_y, quat_z, quat_w;
  logic                               degenerate;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, degenerate,
                  input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, degenerate,
                output ready);
endinterface

@@ rtl/core/rmq_front.sv @@
// ----------------------------------------------------------------------------
// Front end
// Picks the leading component and forms the unnormalized quaternion.
// ----------------------------------------------------------------------------
module rmq_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  rmq_mat_if.sink         mat_i,
  output logic            push_o,
  output rmq_pkg::vec_t   vec_o,
  input  logic            push_rdy_i
);
  localparam int VW = rmq_pkg::VEC_W;

  logic signed [VW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22, tr;
  rmq_pkg::vec_t        vec_d, vec_q;
  logic                 vld_q, vld_d, acc;
  logic signed [VW-1:0] s;

  assign m00 = VW'(mat_i.e00);
  assign m01 = VW'(mat_i.e01);
  assign m02 = VW'(mat_i.e02);
  assign m10 = VW'(mat_i.e10);
  assign m11 = VW'(mat_i.e11);
  assign m12 = VW'(mat_i.e12);
  assign m20 = VW'(mat_i.e20);
  assign m21 = VW'(mat_i.e21);
  assign m22 = VW'(mat_i.e22);
  assign tr  = m00 + m11 + m22;

  always_comb begin
    s = '0;
    vec_d.v = '0;
    if (tr > 0) begin
      s = tr + rmq_pkg::ONE_V;
      vec_d.v[3] = s;
      vec_d.v[0] = m12 - m21;
      vec_d.v[1] = m20 - m02;
      vec_d.v[2] = m01 - m10;
    end else if (m22 > m11 && m22 > m00 || m22 > m00 && !(m11 > m00)) begin
      s = m22 - m00 - m11 + rmq_pkg::ONE_V;
      vec_d.v[2] = s;
      vec_d.v[3] = m01 - m10;
      vec_d.v[0] = m20 + m02;
      vec_d.v[1] = m21 + m12;
    end else if (m11 > m00) begin
      s = m11 - m22 - m00 + rmq_pkg::ONE_V;
      vec_d.v[1] = s;
      vec_d.v[3] = m20 - m02;
      vec_d.v[2] = m12 + m21;
      vec_d.v[0] = m10 + m01;
    end else begin
      s = m00 - m11 - m22 + rmq_pkg::ONE_V;
      vec_d.v[0] = s;
      vec_d.v[3] = m12 - m21;
      vec_d.v[1] = m01 + m10;
      vec_d.v[2] = m02 + m20;
    end
    vec_d.degen = (s < 1);
  end

  assign mat_i.ready = !vld_q || push_rdy_i;
  assign acc         = mat_i.valid && mat_i.ready;
  assign push_o      = vld_q;
  assign vec_o       = vec_q;
  assign vld_d       = acc || (vld_q && !push_rdy_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      vec_q <= vec_d;
    end
  end
endmodule

@@ rtl/core/rmq_fifo.sv @@
// ----------------------------------------------------------------------------
// Decoupling queue
// Small register queue between the front end and the normalizer.
// ----------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_defines.svh"
module rmq_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rmq_pkg::vec_t   data_i,
  output logic            rdy_o,
  input  logic            pop_i,
  output logic            vld_o,
  output rmq_pkg::vec_t   data_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rmq_pkg::vec_t  mem_q [DEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [CW-1:0]  cnt_q;
  logic           do_push, do_pop;

  assign rdy_o   = (cnt_q != CW'(DEPTH));
  assign vld_o   = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && rdy_o;
  assign do_pop  = pop_i && vld_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  `RMQ_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(DEPTH))
  `RMQ_ASSERT_NEXT(a_cnt_inc, clk_i, rst_ni, do_push && !do_pop, cnt_q == $past(cnt_q) + 1'b1)
  `RMQ_ASSERT_NEXT(a_cnt_dec, clk_i, rst_ni, do_pop && !do_push, cnt_q == $past(cnt_q) - 1'b1)
endmodule

@@ rtl/core/rmq_back.sv @@
// ----------------------------------------------------------------------------
// Normalizer
// Scales the vector, takes the square root of its squared norm, divides each
// component by it, one root bit and one quotient bit per stage.
// ----------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_defines.svh"
module rmq_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  rmq_pkg::vec_t   vec_i,
  output logic            pop_o,
  rmq_quat_if.source      quat_o
);
  localparam int VW  = rmq_pkg::VEC_W;
  localparam int NW  = rmq_pkg::NORM_W;
  localparam int AW  = rmq_pkg::ACC_W;
  localparam int RW  = rmq_pkg::ROOT_W;
  localparam int QW  = rmq_pkg::QUO_W;
  localparam int UW  = rmq_pkg::NUM_W;
  localparam int DW  = rmq_pkg::DEN_W;
  localparam int SW  = rmq_pkg::SH_W;
  localparam int DWD = rmq_pkg::DATA_W;

  logic en;

  // Magnitudes, signs and the largest magnitude.
  logic                 b1_vld_q, b1_degen_q;
  logic [3:0]           b1_neg_q;
  logic [3:0][VW-1:0]   b1_mag_q;
  logic [VW-1:0]        b1_mx_q;
  logic [3:0][VW-1:0]   mag_d;
  logic [3:0]           neg_d;
  logic [VW-1:0]        mx_d;

  always_comb begin
    mx_d = '0;
    for (int l = 0; l < 4; l++) begin
      neg_d[l] = vec_i.v[l][VW-1];
      mag_d[l] = neg_d[l] ? VW'(-vec_i.v[l]) : vec_i.v[l];
      if (mag_d[l] > mx_d) begin
        mx_d = mag_d[l];
      end
    end
  end

  // Common left shift so that the largest magnitude lands just below 2^30.
  logic                 b2_vld_q, b2_degen_q;
  logic [3:0]           b2_neg_q;
  rmq_pkg::mag4_t       b2_a_q;
  logic [SW-1:0]        sh;

  always_comb begin
    sh = '0;
    for (int b = 0; b < VW; b++) begin
      if (b1_mx_q[b]) begin
        sh = SW'(NW - 1 - b);
      end
    end
  end

  // Squares and their sum.
  logic                       b3_vld_q, b3_degen_q;
  logic [3:0]                 b3_neg_q;
  rmq_pkg::mag4_t             b3_a_q;
  logic [3:0][2*NW-1:0]       b3_sq_q;

  logic           s_vld_q   [RW+1];
  logic           s_degen_q [RW+1];
  logic [3:0]     s_neg_q   [RW+1];
  rmq_pkg::mag4_t s_a_q     [RW+1];
  logic [AW-1:0]  s_rem_q   [RW+1];
  logic [AW-1:0]  s_res_q   [RW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q   <= 1'b0;
      b2_vld_q   <= 1'b0;
      b3_vld_q   <= 1'b0;
      s_vld_q[0] <= 1'b0;
    end else if (en) begin
      b1_vld_q   <= vld_i;
      b2_vld_q   <= b1_vld_q;
      b3_vld_q   <= b2_vld_q;
      s_vld_q[0] <= b3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_mag_q   <= mag_d;
      b1_neg_q   <= neg_d;
      b1_mx_q    <= mx_d;
      b1_degen_q <= vec_i.degen || (mx_d == '0);
      for (int l = 0; l < 4; l++) begin
        b2_a_q[l] <= NW'({{(NW - VW){1'b0}}, b1_mag_q[l]} << sh);
        b3_sq_q[l] <= b2_a_q[l] * b2_a_q[l];
      end
      b2_neg_q     <= b1_neg_q;
      b2_degen_q   <= b1_degen_q;
      b3_a_q       <= b2_a_q;
      b3_neg_q     <= b2_neg_q;
      b3_degen_q   <= b2_degen_q;
      s_rem_q[0]   <= AW'(b3_sq_q[0]) + AW'(b3_sq_q[1]) + AW'(b3_sq_q[2]) + AW'(b3_sq_q[3]);
      s_res_q[0]   <= '0;
      s_a_q[0]     <= b3_a_q;
      s_neg_q[0]   <= b3_neg_q;
      s_degen_q[0] <= b3_degen_q;
    end
  end

  // Integer square root, one result bit per stage.
  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam logic [AW-1:0] BIT = AW'(1) << (2 * (RW - 1 - k));
    logic [AW-1:0] trial;
    logic          take;
    assign trial = s_res_q[k] + BIT;
    assign take  = (s_rem_q[k] >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s_vld_q[k+1] <= 1'b0;
      end else if (en) begin
        s_vld_q[k+1] <= s_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        s_rem_q[k+1]   <= take ? s_rem_q[k] - trial : s_rem_q[k];
        s_res_q[k+1]   <= take ? (s_res_q[k] >> 1) + BIT : s_res_q[k] >> 1;
        s_a_q[k+1]     <= s_a_q[k];
        s_neg_q[k+1]   <= s_neg_q[k];
        s_degen_q[k+1] <= s_degen_q[k];
      end
    end
  end

  // Rounded division a * ONE / root as (2 a ONE + root) / (2 root).
  logic                      d_vld_q   [QW+1];
  logic                      d_degen_q [QW+1];
  logic [3:0]                d_neg_q   [QW+1];
  logic [DW-1:0]             d_den_q   [QW+1];
  logic [3:0][UW-1:0]        d_rem_q   [QW+1];
  logic [3:0][QW-1:0]        d_quo_q   [QW+1];
  logic [RW-1:0]             root;

  assign root = s_res_q[RW][RW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q[0] <= 1'b0;
    end else if (en) begin
      d_vld_q[0] <= s_vld_q[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        d_rem_q[0][l] <= (UW'(s_a_q[RW][l]) << QW) + UW'(root);
      end
      d_quo_q[0]   <= '0;
      d_den_q[0]   <= {root, 1'b0};
      d_neg_q[0]   <= s_neg_q[RW];
      d_degen_q[0] <= s_degen_q[RW] || (root == '0);
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [UW-1:0] dsh;
    assign dsh = UW'(d_den_q[k]) << (QW - 1 - k);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_vld_q[k+1] <= 1'b0;
      end else if (en) begin
        d_vld_q[k+1] <= d_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int l = 0; l < 4; l++) begin
          if (d_rem_q[k][l] >= dsh) begin
            d_rem_q[k+1][l] <= d_rem_q[k][l] - dsh;
            d_quo_q[k+1][l] <= d_quo_q[k][l] | (QW'(1) << (QW - 1 - k));
          end else begin
            d_rem_q[k+1][l] <= d_rem_q[k][l];
            d_quo_q[k+1][l] <= d_quo_q[k][l];
          end
        end
        d_den_q[k+1]   <= d_den_q[k];
        d_neg_q[k+1]   <= d_neg_q[k];
        d_degen_q[k+1] <= d_degen_q[k];
      end
    end
  end

  // Output register.
  logic                   out_vld_q, out_degen_q;
  logic [3:0][DWD-1:0]    out_q_q, out_d;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (d_degen_q[QW]) begin
        out_d[l] = '0;
      end else if (d_neg_q[QW][l]) begin
        out_d[l] = DWD'(-{1'b0, d_quo_q[QW][l]});
      end else begin
        out_d[l] = DWD'({1'b0, d_quo_q[QW][l]});
      end
    end
  end

  assign en    = !out_vld_q || quat_o.ready;
  assign pop_o = en && vld_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d_vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q_q     <= out_d;
      out_degen_q <= d_degen_q[QW];
    end
  end

  assign quat_o.valid      = out_vld_q;
  assign quat_o.quat_x     = out_q_q[0];
  assign quat_o.quat_y     = out_q_q[1];
  assign quat_o.quat_z     = out_q_q[2];
  assign quat_o.quat_w     = out_q_q[3];
  assign quat_o.degenerate = out_degen_q;

  `RMQ_ASSERT(a_degen_zero, clk_i, rst_ni, (out_vld_q && out_degen_q) |-> (out_q_q == '0))
  `RMQ_ASSERT(a_quo_le_one, clk_i, rst_ni, (d_vld_q[QW] && !d_degen_q[QW]) |-> (d_quo_q[QW][0] <= rmq_pkg::ONE_Q && d_quo_q[QW][1] <= rmq_pkg::ONE_Q && d_quo_q[QW][2] <= rmq_pkg::ONE_Q && d_quo_q[QW][3] <= rmq_pkg::ONE_Q))
  `RMQ_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_vld_q && !quat_o.ready, out_vld_q && $stable(out_q_q))
endmodule

@@ rtl/core/rotation_matrix_to_quaternion.sv @@
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion
// Converts a Q1.14 3x3 rotation matrix into a normalized Q1.14 quaternion.
// ----------------------------------------------------------------------------
// The block takes one matrix per clock cycle while the output is not stalled
// and delivers one quaternion per matrix, in order. An accepted matrix is
// loaded into the front-end register, then passes through the queue, the
// magnitude, shift, square and sum registers, 31 square-root stages (one
// root bit each), one setup and 15 divider stages (one quotient bit each),
// and the output register. The queue of FIFO_DEPTH entries lets the front
// end keep accepting while the output is stalled, until the queue is full.
// The degenerate flag is set, with all four components zero, when the
// leading root term is not positive.
module rotation_matrix_to_quaternion #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rmq_mat_if.sink     mat_i,
  rmq_quat_if.source  quat_o
);
  logic          push, push_rdy, fifo_vld, pop;
  rmq_pkg::vec_t front_vec, fifo_vec;

  rmq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mat_i      (mat_i),
    .push_o     (push),
    .vec_o      (front_vec),
    .push_rdy_i (push_rdy)
  );

  rmq_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_vec),
    .rdy_o  (push_rdy),
    .pop_i  (pop),
    .vld_o  (fifo_vld),
    .data_o (fifo_vec)
  );

  rmq_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (fifo_vld),
    .vec_i  (fifo_vec),
    .pop_o  (pop),
    .quat_o (quat_o)
  );
endmodule

@@ test/tb_rotation_matrix_to_quaternion.sv @@
// ----------------------------------------------------------------------------
// Testbench: rotation matrix to quaternion
// Drives matrices with random gaps, predicts each normalized quaternion in
// fixed point and compares every result in order against the prediction.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [rmq_pkg::DATA_W-1:0] elem_t;
  typedef elem_t mat9_t [9];

  typedef struct {
    logic signed [rmq_pkg::DATA_W-1:0] x, y, z, w;
    logic                              degen;
  } quat_t;

  // Fixed-point conversion of one matrix into the normalized quaternion.
  function automatic quat_t quat_of_matrix(mat9_t e);
    longint     m [3][3];
    longint     v [4];
    longint     s, one, res;
    longint unsigned mx, n, root, rem, bitv, qv, ua;
    int         i, j, k, sh;
    int         nxt [3];
    logic       degen;
    quat_t      q;
    nxt = '{1, 2, 0};
    one = longint'(1) << rmq_pkg::FRAC_BITS;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        m[r][c] = longint'(e[r*3+c]);
    if (m[0][0] + m[1][1] + m[2][2] > 0) begin
      s = m[0][0] + m[1][1] + m[2][2] + one;
      v[3] = s;
      v[0] = m[1][2] - m[2][1];
      v[1] = m[2][0] - m[0][2];
      v[2] = m[0][1] - m[1][0];
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = nxt[i];
      k = nxt[j];
      s = m[i][i] - m[j][j] - m[k][k] + one;
      v[i] = s;
      v[3] = m[j][k] - m[k][j];
      v[j] = m[i][j] + m[j][i];
      v[k] = m[i][k] + m[k][i];
    end
    q = '{default: '0};
    degen = (s < 1);
    mx = 0;
    for (int t = 0; t < 4; t++) begin
      ua = (v[t] < 0) ? -v[t] : v[t];
      if (ua > mx) mx = ua;
    end
    if (mx == 0) degen = 1'b1;
    if (!degen) begin
      sh = 0;
      while ((mx << 1) < (64'd1 << 30)) begin
        mx = mx << 1;
        sh++;
      end
      n = 0;
      for (int t = 0; t < 4; t++) begin
        ua = ((v[t] < 0) ? -v[t] : v[t]) << sh;
        v[t] = (v[t] < 0) ? -longint'(ua) : longint'(ua);
        n += ua * ua;
      end
      // Bitwise integer square root.
      root = 0;
      rem = n;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (rem >= root + bitv) begin
          rem -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      if (root == 0) degen = 1'b1;
      if (!degen) begin
        for (int t = 0; t < 4; t++) begin
          ua = (v[t] < 0) ? -v[t] : v[t];
          qv = (2 * ua * one + root) / (2 * root);
          if (qv > one) qv = one;
          if (qv > 32767 && v[t] >= 0) qv = 32767;
          if (qv > 32768) qv = 32768;
          res = (v[t] < 0) ? -longint'(qv) : longint'(qv);
          case (t)
            0: q.x = res[rmq_pkg::DATA_W-1:0];
            1: q.y = res[rmq_pkg::DATA_W-1:0];
            2: q.z = res[rmq_pkg::DATA_W-1:0];
            default: q.w = res[rmq_pkg::DATA_W-1:0];
          endcase
        end
      end
    end
    if (degen) q = '{x: '0, y: '0, z: '0, w: '0, degen: 1'b1};
    return q;
  endfunction

  class quat_scoreboard;
    quat_t pending_quats[$];
    int    errors;

    function void note_matrix(mat9_t e);
      pending_quats.push_back(quat_of_matrix(e));
    endfunction

    function void check_quat(quat_t got);
      quat_t want;
      if (pending_quats.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d w=%0d d=%0b", $time,
                 got.x, got.y, got.z, got.w, got.degen);
        errors++;
        return;
      end
      want = pending_quats.pop_front();
      if (got.x !== want.x) begin
        $display("%0t: quat_x expected %0d actual %0d", $time, want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $display("%0t: quat_y expected %0d actual %0d", $time, want.y, got.y);
        errors++;
      end
      if (got.z !== want.z) begin
        $display("%0t: quat_z expected %0d actual %0d", $time, want.z, got.z);
        errors++;
      end
      if (got.w !== want.w) begin
        $display("%0t: quat_w expected %0d actual %0d", $time, want.w, got.w);
        errors++;
      end
      if (got.degen !== want.degen) begin
        $display("%0t: degenerate expected %0b actual %0b", $time, want.degen,
                 got.degen);
        errors++;
      end
    endfunction
  endclass

  localparam int RANDOM_ITEMS = 1530;
  localparam int IDLE_LIMIT   = 5000;

  logic clk_i;
  logic rst_ni;
  rmq_mat_if  mat_if ();
  rmq_quat_if quat_if ();

  rotation_matrix_to_quaternion u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mat_i  (mat_if.sink),
    .quat_o (quat_if.source)
  );

  quat_scoreboard sb;
  logic           stim_done;
  logic           long_hold_req;
  int             idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  function automatic elem_t rand_elem();
    case ($urandom_range(0, 5))
      0: return elem_t'(16'sh8000);
      1: return elem_t'(16'sh7fff);
      2: return elem_t'($urandom_range(0, 32768) - 16384);
      default: return elem_t'($urandom);
    endcase
  endfunction

  // Random signed permutation, even sign parity (proper rotation only for
  // even permutations), plus small noise so the leading-axis choice varies.
  function automatic mat9_t rand_rotation();
    mat9_t e;
    int    perm [3];
    int    sgn [3];
    int    tmp, p, a;
    perm = '{0, 1, 2};
    for (int r = 2; r > 0; r--) begin
      a = $urandom_range(0, r);
      tmp = perm[r]; perm[r] = perm[a]; perm[a] = tmp;
    end
    p = 1;
    for (int r = 0; r < 3; r++) begin
      sgn[r] = $urandom_range(0, 1) ? 1 : -1;
      p *= sgn[r];
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        e[r*3+c] = elem_t'((c == perm[r] ? sgn[r] * 16384 : 0)
                           + int'($urandom_range(0, 4000)) - 2000);
    if (p < 0)
      for (int c = 0; c < 3; c++) e[c] = -e[c];
    return e;
  endfunction

  task automatic send_matrix(mat9_t e);
    mat_if.valid <= 1'b1;
    mat_if.e00 <= e[0]; mat_if.e01 <= e[1]; mat_if.e02 <= e[2];
    mat_if.e10 <= e[3]; mat_if.e11 <= e[4]; mat_if.e12 <= e[5];
    mat_if.e20 <= e[6]; mat_if.e21 <= e[7]; mat_if.e22 <= e[8];
    do @(posedge clk_i); while (!mat_if.ready);
    sb.note_matrix(e);
  endtask

  task automatic send_with_gap(mat9_t e, int gap);
    if (gap > 0) begin
      mat_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    send_matrix(e);
  endtask

  task automatic send_directed();
    mat9_t e;
    int    ident [9];
    ident = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
    foreach (e[t]) e[t] = elem_t'(ident[t]);
    send_matrix(e);
    // Half turns about each axis take the negative-trace path for each i.
    for (int ax = 0; ax < 3; ax++) begin
      foreach (e[t]) e[t] = '0;
      for (int d = 0; d < 3; d++) e[d*4] = elem_t'((d == ax) ? 16384 : -16384);
      send_matrix(e);
    end
    foreach (e[t]) e[t] = '0;
    send_matrix(e);
    foreach (e[t]) e[t] = elem_t'(16'sh8000);
    send_matrix(e);
    foreach (e[t]) e[t] = elem_t'(16'sh7fff);
    send_matrix(e);
    foreach (e[t]) e[t] = elem_t'(-16'sd1);
    send_matrix(e);
    // Diagonal just cancelling ONE, and ties between diagonal entries.
    foreach (e[t]) e[t] = '0;
    e[0] = -16'sd16384; send_matrix(e);
    e[0] = 16'sd100; e[4] = 16'sd100; e[8] = -16'sd200; send_matrix(e);
    e[0] = -16'sd8000; e[4] = -16'sd8000; e[8] = -16'sd8000; send_matrix(e);
    // Large off-diagonal terms with diagonal entries of plus or minus one.
    foreach (e[t]) e[t] = elem_t'(16'sh7fff);
    e[0] = 16'sd16384; e[4] = 16'sd16384; e[8] = 16'sd16384; send_matrix(e);
    foreach (e[t]) e[t] = elem_t'(16'sh8000);
    e[0] = -16'sd16384; e[4] = 16'sd16384; e[8] = -16'sd16384; send_matrix(e);
    for (int d = 0; d < 4; d++) send_matrix(rand_rotation());
  endtask

  initial begin
    mat9_t e;
    sb = new();
    stim_done     = 1'b0;
    long_hold_req = 1'b0;
    rst_ni        = 1'b0;
    mat_if.valid  <= 1'b0;
    mat_if.e00 <= '0; mat_if.e01 <= '0; mat_if.e02 <= '0;
    mat_if.e10 <= '0; mat_if.e11 <= '0; mat_if.e12 <= '0;
    mat_if.e20 <= '0; mat_if.e21 <= '0; mat_if.e22 <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_directed();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) long_hold_req <= 1'b1;
      if (n == 700) begin
        // Drain fully before resuming.
        mat_if.valid <= 1'b0;
        while (sb.pending_quats.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 3) == 0) begin
        foreach (e[t]) e[t] = rand_elem();
      end else begin
        e = rand_rotation();
      end
      send_with_gap(e, (n >= 300 && n < 400) || (n >= 1000 && n < 1100) ? 0 : pick_gap());
    end
    mat_if.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Result side: random stalls plus one long hold-off while the sender runs.
  initial begin
    int stall;
    quat_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        long_hold_req <= 1'b0;
        quat_if.ready <= 1'b0;
        repeat (200) @(posedge clk_i);
      end
      stall = ($urandom_range(0, 1) == 0) ? 0 : pick_gap();
      if (stall > 0) begin
        quat_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      quat_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && quat_if.valid && quat_if.ready)
      sb.check_quat('{x: quat_if.quat_x, y: quat_if.quat_y, z: quat_if.quat_z,
                      w: quat_if.quat_w, degen: quat_if.degenerate});
  end

  always @(posedge clk_i) begin
    if ((mat_if.valid && mat_if.ready) || (quat_if.valid && quat_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    idle_cycles = 0;
    fork
      begin
        wait (stim_done);
        while (sb.pending_quats.size() != 0) @(posedge clk_i);
        repeat (100) @(posedge clk_i);
        if (sb.errors == 0 && sb.pending_quats.size() == 0)
          $display("tb_rotation_matrix_to_quaternion: clean");
        else
          $display("tb_rotation_matrix_to_quaternion: errors");
      end
      begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("tb_rotation_matrix_to_quaternion: errors");
      end
    join_any
    $finish;
  end
endmodule
